FILE: rtl/core/flv_aac_to_adts_framer_assert.svh
// Assertion macros for the FLV AAC to ADTS framer.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef FLV_AAC_TO_ADTS_FRAMER_ASSERT_SVH
`define FLV_AAC_TO_ADTS_FRAMER_ASSERT_SVH

// check a property on every rising clock edge outside reset
`define FLVADTS_CHECK(name, clk, rstn, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// check that a condition never holds outside reset
`define FLVADTS_NEVER(name, clk, rstn, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

FILE: rtl/core/flvadts_pkg.sv
// Shared types, constants and helpers of the FLV AAC to ADTS framer.
// No dependencies.
`default_nettype none

package flvadts_pkg;

	localparam int MAX_RES = 7;
	localparam int CNT_W   = $clog2(MAX_RES + 1);
	localparam int FLEN_W  = 13;
	localparam int POS_W   = 3;

	localparam logic [1:0] KIND_PASS = 2'd0;
	localparam logic [1:0] KIND_HDR  = 2'd1;
	localparam logic [1:0] KIND_PAY  = 2'd2;

	localparam logic [7:0] SYNC_BYTE     = 8'hff;
	localparam logic [7:0] SYNC_ID_BYTE  = 8'hf1;
	localparam logic [7:0] HDR_END_BYTE  = 8'hfc;
	localparam logic [7:0] AAC_SEQ_HDR   = 8'h00;
	localparam logic [7:0] AAC_RAW       = 8'h01;
	localparam int         SEQ_MIN_BYTES = 4;
	localparam int         FRAME_ADD     = 5;

	typedef struct packed {
		logic [7:0]        data;
		logic              first;
		logic              last;
		logic [FLEN_W-1:0] len;
	} item_t;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] kind;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [CNT_W-1:0]       cnt;
		res_t [MAX_RES-1:0]     ent;
	} res_set_t;

	function automatic res_t mk_res(logic [7:0] data, logic [1:0] kind, logic last);
		res_t r;
		r.data = data;
		r.kind = kind;
		r.last = last;
		return r;
	endfunction

	function automatic logic [1:0] profile_of(logic [4:0] obj);
		logic [1:0] p;
		case (obj)
			5'd1:                p = 2'd0;
			5'd2, 5'd5, 5'd29:   p = 2'd1;
			5'd3:                p = 2'd2;
			default:             p = 2'd3;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/flvadts_in_stage.sv
// Input register of the framer: holds one accepted item until the parser takes it.
// Depends on flvadts_pkg.
`default_nettype none

module flvadts_in_stage (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  flvadts_pkg::item_t  in_item,
	input  wire                 take,
	output logic                valid_s1,
	output flvadts_pkg::item_t  item_s1
);
	import flvadts_pkg::*;

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/flvadts_parse.sv
// Packet parser: tracks the tag state and builds the result items of one input item.
// Depends on flvadts_pkg.
`default_nettype none

module flvadts_parse #(
	parameter int LENGTH_BITS = 13
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  flvadts_pkg::item_t     item_s1,
	input  wire                    take,
	output flvadts_pkg::res_set_t  res_set
);
	import flvadts_pkg::*;

	typedef enum logic [1:0] {
		MODE_UNDEC   = 2'd0,
		MODE_PASS    = 2'd1,
		MODE_ADTS    = 2'd2,
		MODE_CONSUME = 2'd3
	} mode_t;

	mode_t             mode_q, mode_n;
	logic [POS_W-1:0]  pos_q, pos_n;
	logic              seen_q, seen_n;
	logic [4:0]        obj_q, obj_n;
	logic [3:0]        rate_q, rate_n;
	logic [3:0]        chan_q, chan_n;
	logic [7:0]        held_q, held_n;
	logic [7:0]        objb_q, objb_n;
	logic [FLEN_W-1:0] flen_q, flen_n;
	logic [FLEN_W-1:0] decl_q, decl_n;
	logic [LENGTH_BITS-1:0] len_sum;

	assign len_sum = LENGTH_BITS'(item_s1.len) + LENGTH_BITS'(FRAME_ADD);

	always_comb begin
		mode_n  = mode_q;
		pos_n   = pos_q;
		seen_n  = seen_q;
		obj_n   = obj_q;
		rate_n  = rate_q;
		chan_n  = chan_q;
		held_n  = held_q;
		objb_n  = objb_q;
		flen_n  = flen_q;
		decl_n  = decl_q;
		res_set = '0;
		if (item_s1.first) begin
			decl_n = item_s1.len;
			flen_n = len_sum[FLEN_W-1:0];
			if (item_s1.data == SYNC_BYTE || item_s1.last) begin
				res_set.cnt    = CNT_W'(1);
				res_set.ent[0] = mk_res(item_s1.data, KIND_PASS, item_s1.last);
				mode_n = item_s1.last ? MODE_UNDEC : MODE_PASS;
				pos_n  = item_s1.last ? POS_W'(0) : POS_W'(1);
			end else begin
				held_n = item_s1.data;
				mode_n = MODE_UNDEC;
				pos_n  = POS_W'(1);
			end
		end else if (mode_q == MODE_UNDEC) begin
			if (pos_q == POS_W'(0)) begin
				res_set.cnt    = CNT_W'(1);
				res_set.ent[0] = mk_res(item_s1.data, KIND_PASS, item_s1.last);
			end else begin
				if (item_s1.data == AAC_SEQ_HDR && decl_q >= FLEN_W'(SEQ_MIN_BYTES)) begin
					mode_n = MODE_CONSUME;
				end else if (item_s1.data == AAC_RAW && seen_q) begin
					res_set.cnt    = CNT_W'(MAX_RES);
					res_set.ent[0] = mk_res(SYNC_BYTE, KIND_HDR, 1'b0);
					res_set.ent[1] = mk_res(SYNC_ID_BYTE, KIND_HDR, 1'b0);
					res_set.ent[2] = mk_res({profile_of(obj_q), rate_q, 1'b0, chan_q[2]},
						KIND_HDR, 1'b0);
					res_set.ent[3] = mk_res({chan_q[1:0], 4'b0000, flen_q[12:11]},
						KIND_HDR, 1'b0);
					res_set.ent[4] = mk_res(flen_q[10:3], KIND_HDR, 1'b0);
					res_set.ent[5] = mk_res({flen_q[2:0], 5'b00000}, KIND_HDR, 1'b0);
					res_set.ent[6] = mk_res(HDR_END_BYTE, KIND_HDR, item_s1.last);
					mode_n = MODE_ADTS;
				end else begin
					res_set.cnt    = CNT_W'(2);
					res_set.ent[0] = mk_res(held_q, KIND_PASS, 1'b0);
					res_set.ent[1] = mk_res(item_s1.data, KIND_PASS, item_s1.last);
					mode_n = MODE_PASS;
				end
				pos_n = POS_W'(2);
				if (item_s1.last) begin
					mode_n = MODE_UNDEC;
					pos_n  = POS_W'(0);
				end
			end
		end else begin
			unique case (mode_q)
				MODE_PASS: begin
					res_set.cnt    = CNT_W'(1);
					res_set.ent[0] = mk_res(item_s1.data, KIND_PASS, item_s1.last);
				end
				MODE_ADTS: begin
					res_set.cnt    = CNT_W'(1);
					res_set.ent[0] = mk_res(item_s1.data, KIND_PAY, item_s1.last);
				end
				default: begin
					if (pos_q == POS_W'(2)) begin
						objb_n = item_s1.data;
					end else if (pos_q == POS_W'(3)) begin
						chan_n = item_s1.data[6:3];
						rate_n = {objb_q[2:0], item_s1.data[7]};
						obj_n  = objb_q[7:3];
						seen_n = 1'b1;
					end
				end
			endcase
			if (pos_q < POS_W'(4)) begin
				pos_n = pos_q + POS_W'(1);
			end
			if (item_s1.last) begin
				mode_n = MODE_UNDEC;
				pos_n  = POS_W'(0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_UNDEC;
			pos_q  <= '0;
			seen_q <= 1'b0;
			obj_q  <= '0;
			rate_q <= '0;
			chan_q <= '0;
			held_q <= '0;
			objb_q <= '0;
			flen_q <= '0;
			decl_q <= '0;
		end else if (take) begin
			mode_q <= mode_n;
			pos_q  <= pos_n;
			seen_q <= seen_n;
			obj_q  <= obj_n;
			rate_q <= rate_n;
			chan_q <= chan_n;
			held_q <= held_n;
			objb_q <= objb_n;
			flen_q <= flen_n;
			decl_q <= decl_n;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/flvadts_burst.sv
// Result buffer: holds one input item's results; shifts out one per cycle unless stalled.
// Depends on flvadts_pkg and flv_aac_to_adts_framer_assert.svh.
`default_nettype none

`include "flv_aac_to_adts_framer_assert.svh"

module flvadts_burst (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    valid_s1,
	input  flvadts_pkg::res_set_t  res_set,
	output logic                   take,
	output logic                   out_valid,
	input  wire                    out_ready,
	output flvadts_pkg::res_t      out_res
);
	import flvadts_pkg::*;

	logic [CNT_W-1:0]   cnt_q;
	res_t [MAX_RES-1:0] ent_q;
	logic               shift;

	assign out_valid = (cnt_q != '0);
	assign out_res   = ent_q[0];
	assign take      = valid_s1 && ((cnt_q == '0) || (cnt_q == CNT_W'(1) && out_ready));
	assign shift     = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (take) begin
			cnt_q <= res_set.cnt;
		end else if (shift) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ent_q <= res_set.ent;
		end else if (shift) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				ent_q[i] <= ent_q[i+1];
			end
		end
	end

	`FLVADTS_NEVER(a_cnt_range, clk, arst_n, cnt_q > CNT_W'(MAX_RES), "result count out of range")
	`FLVADTS_CHECK(a_load_cnt, clk, arst_n, take |=> cnt_q == $past(res_set.cnt), "load count lost")
	`FLVADTS_CHECK(a_shift_cnt, clk, arst_n, (shift && !take) |=> cnt_q == $past(cnt_q) - CNT_W'(1), "shift count wrong")
	`FLVADTS_CHECK(a_last_tail, clk, arst_n, (out_valid && out_res.last) |-> cnt_q == CNT_W'(1), "last item not at tail")

endmodule

`default_nettype wire

FILE: rtl/core/flv_aac_to_adts_framer.sv
// FLV AAC audio tag to ADTS framer, top level.
// Depends on flvadts_pkg, flvadts_in_stage, flvadts_parse and flvadts_burst.
//
// Input stream: one byte of an FLV audio tag payload per item. s_axis_tuser marks the
// first byte of a packet, s_axis_tlast the last, and the packet byte count rides in
// tdata alongside the first byte. Output stream: one byte per item, with its kind
// (passed through, ADTS header, ADTS payload) in tuser and the end of an output
// packet on tlast.
// AAC sequence headers are consumed and set the stored stream configuration; raw AAC
// packets lose their two tag bytes and gain a seven-byte ADTS header.
// Throughput: one item per cycle while the receiver is ready and each item yields at most
// one result; the byte that opens an ADTS frame yields seven result items, which the
// single output port drains one at a time while one further input item waits in the
// input register. A first byte that is held back yields no result.
// Reset clears the stored header and the packet tracking; no header is then known and
// raw packets pass unchanged until a sequence header arrives.
// A stalled receiver holds the current output item; input acceptance stops once the
// input register and the result buffer are both occupied.
`default_nettype none

module flv_aac_to_adts_framer #(
	parameter int LENGTH_BITS = 13
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [23:0] s_axis_tdata,   // [7:0] data_byte, [20:8] packet_bytes, [23:21] zero
	input  wire         s_axis_tuser,   // [0] first_flag
	input  wire         s_axis_tlast,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic [1:0]  m_axis_tuser,   // [1:0] out_kind
	output logic        m_axis_tlast
);
	import flvadts_pkg::*;

	item_t    in_item;
	item_t    item_s1;
	logic     valid_s1;
	logic     take;
	res_set_t res_set;
	res_t     out_res;

	always_comb begin
		in_item.data  = s_axis_tdata[7:0];
		in_item.len   = s_axis_tdata[20:8];
		in_item.first = s_axis_tuser;
		in_item.last  = s_axis_tlast;
	end

	flvadts_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	flvadts_parse #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_s1 (item_s1),
		.take    (take),
		.res_set (res_set)
	);

	flvadts_burst u_burst (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res_set   (res_set),
		.take      (take),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = out_res.data;
	assign m_axis_tuser = out_res.kind;
	assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire

FILE: tb/adts_frame_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the FLV AAC to ADTS framer: watches both streams, predicts every output item.
// Depends on flvadts_pkg for item types, kind codes and header constants.
module adts_frame_checker #(
	parameter int LENGTH_BITS = 13
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              s_axis_tvalid,
	input  wire              s_axis_tready,
	input  wire  [23:0]      s_axis_tdata,
	input  wire              s_axis_tuser,
	input  wire              s_axis_tlast,
	input  wire              m_axis_tvalid,
	input  wire              m_axis_tready,
	input  wire  [7:0]       m_axis_tdata,
	input  wire  [1:0]       m_axis_tuser,
	input  wire              m_axis_tlast,
	output int unsigned      fail_count,
	output int unsigned      pending
);

	import flvadts_pkg::*;

	typedef enum logic [1:0] {MODE_IDLE, MODE_PASS, MODE_ADTS, MODE_DROP} mode_t;

	res_t        expected_bytes[$];
	int unsigned mismatches;

	logic        have_config;
	logic [4:0]  obj_type;
	logic [3:0]  rate_idx;
	logic [3:0]  chan_cfg;
	logic [12:0] pos;
	logic [7:0]  held_tag_byte;
	mode_t       mode;
	logic [12:0] adts_len;
	logic [7:0]  held_asc_byte;
	logic [12:0] declared;

	task automatic emit(input logic [7:0] data, input logic [1:0] kind, input logic last);
		res_t r;
		r.data = data;
		r.kind = kind;
		r.last = last;
		expected_bytes.push_back(r);
	endtask

	task automatic frame_input_byte(input item_t it);
		int         len_sum;
		logic [1:0] profile;
		case (obj_type)
			5'd1:              profile = 2'd0;
			5'd2, 5'd5, 5'd29: profile = 2'd1;
			5'd3:              profile = 2'd2;
			default:           profile = 2'd3;
		endcase
		if (it.first) begin
			mode = MODE_IDLE;
			pos = '0;
			declared = it.len;
			len_sum = (int'(it.len) + FRAME_ADD) % (1 << LENGTH_BITS);
			adts_len = len_sum[12:0];
			if (it.data == SYNC_BYTE || it.last) begin
				emit(it.data, KIND_PASS, it.last);
				if (!it.last) begin
					mode = MODE_PASS;
					pos = 13'd1;
				end
			end else begin
				held_tag_byte = it.data;
				pos = 13'd1;
			end
		end else if (mode == MODE_IDLE && pos == '0) begin
			emit(it.data, KIND_PASS, it.last);
		end else if (mode == MODE_IDLE) begin
			if (it.data == AAC_SEQ_HDR && declared >= SEQ_MIN_BYTES) begin
				mode = MODE_DROP;
			end else if (it.data == AAC_RAW && have_config) begin
				emit(SYNC_BYTE, KIND_HDR, 1'b0);
				emit(SYNC_ID_BYTE, KIND_HDR, 1'b0);
				emit({profile, rate_idx, 1'b0, chan_cfg[2]}, KIND_HDR, 1'b0);
				emit({chan_cfg[1:0], 4'b0000, adts_len[12:11]}, KIND_HDR, 1'b0);
				emit(adts_len[10:3], KIND_HDR, 1'b0);
				emit({adts_len[2:0], 5'b00000}, KIND_HDR, 1'b0);
				emit(HDR_END_BYTE, KIND_HDR, it.last);
				mode = MODE_ADTS;
			end else begin
				emit(held_tag_byte, KIND_PASS, 1'b0);
				emit(it.data, KIND_PASS, it.last);
				mode = MODE_PASS;
			end
			pos = 13'd2;
		end else begin
			case (mode)
				MODE_PASS: emit(it.data, KIND_PASS, it.last);
				MODE_ADTS: emit(it.data, KIND_PAY, it.last);
				default: begin
					if (pos == 13'd2) begin
						held_asc_byte = it.data;
					end else if (pos == 13'd3) begin
						chan_cfg = it.data[6:3];
						rate_idx = {held_asc_byte[2:0], it.data[7]};
						obj_type = held_asc_byte[7:3];
						have_config = 1'b1;
					end
				end
			endcase
			if (pos != 13'h1fff)
				pos = pos + 13'd1;
		end
		if (it.last) begin
			mode = MODE_IDLE;
			pos = '0;
		end
	endtask

	task automatic check_output(input res_t got);
		res_t want;
		if (expected_bytes.size() == 0) begin
			$error("unexpected output item: out_byte %02h out_kind %0d out_last %0d",
				got.data, got.kind, got.last);
			mismatches++;
		end else begin
			want = expected_bytes.pop_front();
			if (got.data !== want.data) begin
				$error("out_byte: expected %02h, actual %02h", want.data, got.data);
				mismatches++;
			end
			if (got.kind !== want.kind) begin
				$error("out_kind: expected %0d, actual %0d", want.kind, got.kind);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$error("out_last: expected %0d, actual %0d", want.last, got.last);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		item_t in_item;
		res_t  out_item;
		if (!arst_n) begin
			have_config = 1'b0;
			obj_type = '0;
			rate_idx = '0;
			chan_cfg = '0;
			pos = '0;
			held_tag_byte = '0;
			mode = MODE_IDLE;
			adts_len = '0;
			held_asc_byte = '0;
			declared = '0;
			expected_bytes.delete();
			mismatches = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				out_item.data = m_axis_tdata;
				out_item.kind = m_axis_tuser;
				out_item.last = m_axis_tlast;
				check_output(out_item);
			end
			if (s_axis_tvalid && s_axis_tready) begin
				in_item.data = s_axis_tdata[7:0];
				in_item.len = s_axis_tdata[20:8];
				in_item.first = s_axis_tuser;
				in_item.last = s_axis_tlast;
				frame_input_byte(in_item);
			end
			fail_count <= mismatches;
			pending <= expected_bytes.size();
		end
	end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the FLV AAC to ADTS framer: clock, reset, packet stimulus and verdict.
// Depends on flv_aac_to_adts_framer, flvadts_pkg and adts_frame_checker.
module tb_top;

	import flvadts_pkg::*;

	localparam int ITEM_TARGET    = 380;
	localparam int QUIET_FROM     = 330;
	localparam int DRAIN_AT       = 150;
	localparam int WATCHDOG_LIMIT = 500;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	wire         s_axis_tready;
	logic [23:0] s_axis_tdata;   // [7:0] data_byte, [20:8] packet_bytes, [23:21] zero
	logic        s_axis_tuser;   // [0] first_flag
	logic        s_axis_tlast;
	wire         m_axis_tvalid;
	logic        m_axis_tready;
	wire  [7:0]  m_axis_tdata;   // [7:0] out_byte
	wire  [1:0]  m_axis_tuser;   // [1:0] out_kind
	wire         m_axis_tlast;

	int unsigned checker_fails;
	int unsigned checker_pending;
	int unsigned items_sent;
	int unsigned stall_cycles;
	bit          bursts_on;
	logic [7:0]  pkt_buf[$];

	flv_aac_to_adts_framer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	adts_frame_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (checker_fails),
		.pending       (checker_pending)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (bursts_on && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	task automatic send_byte(input logic [7:0] data, input logic first, input logic last,
		input logic [12:0] len);
		if (bursts_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, len, data};
		s_axis_tuser <= first;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
		if (items_sent >= QUIET_FROM)
			bursts_on = 1'b0;
	endtask

	// send pkt_buf as one packet; an open packet carries no last mark
	task automatic send_packet(input logic [12:0] declared, input bit closed);
		for (int i = 0; i < pkt_buf.size(); i++)
			send_byte(pkt_buf[i], i == 0, closed && i == pkt_buf.size() - 1,
				i == 0 ? declared : 13'($urandom));
	endtask

	task automatic wait_for_drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (checker_pending != 0) @(posedge clk);
	endtask

	initial begin
		int          sel;
		int          n;
		logic [4:0]  obj;
		logic [3:0]  rate;
		logic [3:0]  chans;
		logic [12:0] declared;
		bit          drained;

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		items_sent = 0;
		stall_cycles = 0;
		bursts_on = 1'b1;
		drained = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray byte outside any packet
		send_byte(8'h00, 1'b0, 1'b1, 13'h1fff);
		// lone byte, first and last together
		pkt_buf = '{8'h5a};                  send_packet(13'd1, 1'b1);
		// raw AAC before any sequence header passes unchanged
		pkt_buf = '{8'haf, 8'h01};           send_packet(13'd2, 1'b1);
		// packet opening with the sync byte
		pkt_buf = '{8'hff, 8'h55};           send_packet(13'd2, 1'b1);
		// sequence header declared too short
		pkt_buf = '{8'haf, 8'h00, 8'h12};    send_packet(13'd3, 1'b1);
		// sequence header ending early
		pkt_buf = '{8'haf, 8'h00, 8'h12};    send_packet(13'd4, 1'b1);
		// full sequence header, all config bits set
		pkt_buf = '{8'haf, 8'h00, 8'hff, 8'hff}; send_packet(13'd4, 1'b1);
		pkt_buf = '{8'haf, 8'h01, 8'h80};    send_packet(13'd3, 1'b1);
		// raw AAC ending on its type byte
		pkt_buf = '{8'haf, 8'h01};           send_packet(13'd2, 1'b1);
		// other packet type
		pkt_buf = '{8'haf, 8'h02};           send_packet(13'd2, 1'b1);
		// abandoned frame, then a wrapped frame length
		pkt_buf = '{8'haf, 8'h01};           send_packet(13'd9, 1'b0);
		pkt_buf = '{8'haf, 8'h01, 8'hee};    send_packet(13'h1fff, 1'b1);

		while (items_sent < ITEM_TARGET) begin
			if (!drained && items_sent >= DRAIN_AT) begin
				wait_for_drain();
				drained = 1'b1;
			end
			pkt_buf.delete();
			sel = $urandom_range(0, 99);
			if (sel < 15) begin
				case ($urandom_range(0, 5))
					0:       obj = 5'd1;
					1:       obj = 5'd2;
					2:       obj = 5'd3;
					3:       obj = 5'd5;
					4:       obj = 5'd29;
					default: obj = 5'($urandom);
				endcase
				rate = 4'($urandom);
				chans = 4'($urandom);
				pkt_buf.push_back(8'($urandom_range(0, 254)));
				pkt_buf.push_back(AAC_SEQ_HDR);
				pkt_buf.push_back({obj, rate[3:1]});
				pkt_buf.push_back({rate[0], chans, 3'($urandom)});
				n = $urandom_range(0, 3);
				repeat (n) pkt_buf.push_back(8'($urandom));
			end else if (sel < 60) begin
				pkt_buf.push_back(8'($urandom_range(0, 254)));
				pkt_buf.push_back(AAC_RAW);
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 20);
				repeat (n) pkt_buf.push_back(8'($urandom));
			end else if (sel < 70) begin
				pkt_buf.push_back(8'($urandom_range(0, 254)));
				pkt_buf.push_back(($urandom_range(0, 2) == 0) ? AAC_SEQ_HDR :
					8'($urandom_range(2, 255)));
				n = $urandom_range(0, 4);
				repeat (n) pkt_buf.push_back(8'($urandom));
			end else if (sel < 78) begin
				pkt_buf.push_back(SYNC_BYTE);
				n = $urandom_range(0, 6);
				repeat (n) pkt_buf.push_back(8'($urandom));
			end else if (sel < 84) begin
				pkt_buf.push_back(8'($urandom));
			end else if (sel < 90) begin
				n = $urandom_range(1, 3);
				repeat (n) send_byte(8'($urandom), 1'b0, 1'($urandom), 13'($urandom));
			end else begin
				n = $urandom_range(1, 6);
				repeat (n) pkt_buf.push_back(8'($urandom));
			end
			if (pkt_buf.size() != 0) begin
				declared = 13'(pkt_buf.size());
				if ($urandom_range(0, 7) == 0)
					declared = 13'($urandom_range(1, 8191));
				send_packet(declared, sel < 90);
			end
		end

		wait_for_drain();
		repeat (20) @(posedge clk);
		if (checker_fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/flvadts_pkg.sv
rtl/core/flvadts_in_stage.sv
rtl/core/flvadts_parse.sv
rtl/core/flvadts_burst.sv
rtl/core/flv_aac_to_adts_framer.sv
tb/adts_frame_checker.sv
tb/tb_top.sv
